// ----- rtl/msd_pkg.sv -----
// Shared types, character codes and the Morse code table for the Morse symbol decoder.
// No dependencies; used by msd_decode and morse_symbol_decoder.
`timescale 1ns / 1ps

package msd_pkg;

  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChDash    = 8'h2D;
  localparam logic [7:0] ChSubmit  = 8'h2A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChUnknown = 8'h3F;

  typedef struct packed {
    logic       action;
    logic [7:0] char_in;
  } msd_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       unknown_code;
  } msd_out_t;

  // Table index is (1 << length) + code for lengths 1 to 5, with the oldest
  // symbol in the highest code bit and a dash as 1. Zero means no entry.
  function automatic logic [7:0] code_char(input logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'd2:  c = "E";
      6'd3:  c = "T";
      6'd4:  c = "I";
      6'd5:  c = "A";
      6'd6:  c = "N";
      6'd7:  c = "M";
      6'd8:  c = "S";
      6'd9:  c = "U";
      6'd10: c = "R";
      6'd11: c = "W";
      6'd12: c = "D";
      6'd13: c = "K";
      6'd14: c = "G";
      6'd15: c = "O";
      6'd16: c = "H";
      6'd17: c = "V";
      6'd18: c = "F";
      6'd20: c = "L";
      6'd22: c = "P";
      6'd23: c = "J";
      6'd24: c = "B";
      6'd25: c = "X";
      6'd26: c = "C";
      6'd27: c = "Y";
      6'd28: c = "Z";
      6'd29: c = "Q";
      6'd32: c = "5";
      6'd33: c = "4";
      6'd35: c = "3";
      6'd39: c = "2";
      6'd47: c = "1";
      6'd48: c = "6";
      6'd56: c = "7";
      6'd60: c = "8";
      6'd62: c = "9";
      6'd63: c = "0";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/msd_decode.sv -----
// Combinational step of the Morse symbol decoder: next pending sequence and result.
// Depends on msd_pkg for the beat types, character codes and the code table.
`timescale 1ns / 1ps

module msd_decode #(
  parameter int MAX_SYMBOLS = 5,
  parameter int CntW        = $clog2(MAX_SYMBOLS + 2)
) (
  input  msd_pkg::msd_in_t       item_i,
  input  logic [MAX_SYMBOLS-1:0] bits_i,
  input  logic [CntW-1:0]        count_i,
  output logic [MAX_SYMBOLS-1:0] bits_o,
  output logic [CntW-1:0]        count_o,
  output logic                   emit_o,
  output msd_pkg::msd_out_t      result_o
);

  localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_SYMBOLS);
  localparam logic [CntW-1:0] OvflCnt = CntW'(MAX_SYMBOLS + 1);

  logic [5:0] idx;
  logic [7:0] table_char;

  // Only lengths one to five have table entries; longer lengths and the
  // overflow mark fall through to an empty index and decode as unknown.
  always_comb begin
    case (count_i)
      CntW'(1): idx = 6'd2  + {5'd0, bits_i[0]};
      CntW'(2): idx = 6'd4  + {4'd0, bits_i[1:0]};
      CntW'(3): idx = 6'd8  + {3'd0, bits_i[2:0]};
      CntW'(4): idx = 6'd16 + {2'd0, bits_i[3:0]};
      CntW'(5): idx = 6'd32 + {1'd0, bits_i[4:0]};
      default:  idx = 6'd0;
    endcase
  end

  assign table_char = msd_pkg::code_char(idx);

  always_comb begin
    bits_o   = bits_i;
    count_o  = count_i;
    emit_o   = 1'b0;
    result_o = '{out_char: item_i.char_in, unknown_code: 1'b0};
    if (item_i.action) begin
      bits_o  = '0;
      count_o = '0;
      emit_o  = 1'b1;
    end else if (item_i.char_in == msd_pkg::ChDot || item_i.char_in == msd_pkg::ChDash) begin
      if (count_i < MaxCnt) begin
        bits_o  = {bits_i[MAX_SYMBOLS-2:0], item_i.char_in == msd_pkg::ChDash};
        count_o = count_i + CntW'(1);
      end else begin
        count_o = OvflCnt;
      end
    end else if (item_i.char_in == msd_pkg::ChSubmit) begin
      if (count_i != '0) begin
        emit_o  = 1'b1;
        bits_o  = '0;
        count_o = '0;
        if (table_char != 8'h00) begin
          result_o.out_char = table_char;
        end else begin
          result_o = '{out_char: msd_pkg::ChUnknown, unknown_code: 1'b1};
        end
      end
    end else if (item_i.char_in == msd_pkg::ChSpace) begin
      emit_o = 1'b1;
    end
  end

endmodule

// ----- rtl/morse_symbol_decoder.sv -----
// Top level of the Morse symbol decoder: input register, decode step, result register.
// Depends on msd_pkg and msd_decode.
`timescale 1ns / 1ps

// One character enters per beat and its result, if it has one, goes via the
// input register and leaves the result register when the output is ready. With
// the output side ready the block takes one item every cycle; the input
// register keeps accepting while a result waits, so a stall costs at most one
// buffered item before in_ready_o drops. The pending dot/dash sequence updates
// only when an item moves from the input register into the decode step.
module morse_symbol_decoder #(
  parameter int MAX_SYMBOLS = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  msd_pkg::msd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output msd_pkg::msd_out_t out_data_o
);

  localparam int CntW = $clog2(MAX_SYMBOLS + 2);

  logic                   item_valid_q;
  msd_pkg::msd_in_t       item_q;
  logic [MAX_SYMBOLS-1:0] bits_q, bits_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   out_valid_q;
  msd_pkg::msd_out_t      out_q;
  logic                   emit;
  msd_pkg::msd_out_t      result;
  logic                   advance;

  // The buffered item moves on once the result register is free or draining.
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  msd_decode #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .CntW       (CntW)
  ) u_decode (
    .item_i  (item_q),
    .bits_i  (bits_q),
    .count_i (count_q),
    .bits_o  (bits_d),
    .count_o (count_d),
    .emit_o  (emit),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      bits_q       <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (advance) begin
        bits_q      <= bits_d;
        count_q     <= count_d;
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
